// ----- rtl/mtavg_pkg.sv -----
package mtavg_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_CELL     = 64;
   localparam int HEIGHT_LIMIT = 4096;

   localparam int COORD_W = 12;
   localparam int CELL_W  = 7;
   localparam int DIM_W   = 13;
   localparam int SUM_W   = 20;
   localparam int CHAN_W  = 8;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);

   localparam logic [1:0] REG_TILE_SIDE    = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   typedef logic [SUM_W-1:0] sum_type;

endpackage

// ----- rtl/mtavg_ram.sv -----
module mtavg_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mosaic_tile_average.sv -----
// Mosaic tile averager.
// req_* carries RGB pixels in raster order, one request per pixel, for a frame
// of image_width by image_height pixels. The frame is cut into square tiles of
// a configured side, clipped at the right and bottom edges.
// rsp_* carries one request per completed tile: its column and row and the
// truncated mean of each channel; rsp_tuser flags the last tile of the frame.
// csr_* writes the tile side, image_width and image_height; write only while idle.
// Steps: a pixel that closes no tile is accepted, its sum is read, and the sum
// is updated. A pixel that closes a tile goes on: the tile's pixel count is
// formed, a shared restoring divider retires one quotient bit per cycle for all
// three channels, and the result is loaded into the output register. A new pixel
// is accepted only once the previous one has finished all of its steps.
// Per-tile-column sums live in one 4096-entry RAM (read-modify-write).
// Reset clears the position counters and loads the register defaults
// (8, 640, 480); the sum RAM needs no clearing pass, the first pixel of
// a tile overwrites its entry.
// A stalled receiver holds the result in the output register; the next pixel
// is still accepted and processed, and only a second finished tile waits.
module mosaic_tile_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tile_column[11:0], tile_row[23:12], average_red[31:24],
   // average_green[39:32], average_blue[47:40]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser,   // frame_done[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int CW = mtavg_pkg::COORD_W;
   localparam int KW = mtavg_pkg::CELL_W;
   localparam int DW = mtavg_pkg::DIM_W;
   localparam int SW = mtavg_pkg::SUM_W;
   localparam int PW = CW + KW;   // tile index times cell size
   localparam int RW = DW + 1;    // divider remainder

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_ACC, ST_CNT, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [KW-1:0] cell_ff;
   logic [DW-1:0] width_ff, height_ff;

   // position counters
   logic [CW-1:0] pc_ff, pr_ff, ctc_ff, ctr_ff;
   logic [5:0]    cit_ff, rit_ff;

   // captured pixel and tile info
   logic [7:0]    pix_ff [3];
   logic [KW-1:0] tw_ff, th_ff;
   logic [DW-1:0] cnt_ff;
   logic [CW-1:0] tcol_ff, trow_ff;
   logic          fdone_ff;

   // divider
   mtavg_pkg::sum_type dvd_ff [3];
   logic [RW-1:0]      rem_ff [3];
   logic [4:0]         step_ff;

   // output register
   logic          rsp_valid_ff;
   logic [47:0]   rsp_data_ff;
   logic          rsp_user_ff;

   // clamped registers
   logic [KW-1:0] cs;
   logic [DW-1:0] w, h;

   always_comb begin
      cs = cell_ff;
      if (cell_ff == '0) cs = KW'(1);
      else if (cell_ff > KW'(mtavg_pkg::MAX_CELL)) cs = KW'(mtavg_pkg::MAX_CELL);
      w = width_ff;
      if (width_ff == '0) w = DW'(1);
      else if (width_ff > DW'(mtavg_pkg::MAX_WIDTH)) w = DW'(mtavg_pkg::MAX_WIDTH);
      h = height_ff;
      if (height_ff == '0) h = DW'(1);
      else if (height_ff > DW'(mtavg_pkg::HEIGHT_LIMIT)) h = DW'(mtavg_pkg::HEIGHT_LIMIT);
   end

   // tile origin products
   logic [PW-1:0] col_base, row_base;
   assign col_base = PW'(ctc_ff) * PW'(cs);
   assign row_base = PW'(ctr_ff) * PW'(cs);

   logic restart;
   assign restart = ({1'b0, pc_ff} >= w) || ({1'b0, pr_ff} >= h)
                  || ({1'b0, cit_ff} >= cs) || ({1'b0, rit_ff} >= cs)
                  || (col_base + PW'(cit_ff) != PW'(pc_ff))
                  || (row_base + PW'(rit_ff) != PW'(pr_ff));

   // sum RAM: {blue, green, red}
   logic                       ram_we, ram_re;
   logic [mtavg_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [3*SW-1:0]            ram_wdata, ram_rdata;

   mtavg_ram #(.WIDTH(3*SW), .DEPTH(mtavg_pkg::MAX_WIDTH)) u_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_re    = (state_ff == ST_CHECK);
   assign ram_raddr = restart ? '0 : mtavg_pkg::ADDR_W'(ctc_ff);
   assign ram_we    = (state_ff == ST_ACC);
   assign ram_waddr = mtavg_pkg::ADDR_W'(ctc_ff);

   // accumulate
   logic               first_px;
   mtavg_pkg::sum_type new_sum [3];
   assign first_px = (cit_ff == '0) && (rit_ff == '0);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         new_sum[c] = first_px ? SW'(pix_ff[c])
                               : ram_rdata[c*SW +: SW] + SW'(pix_ff[c]);
      end
   end
   assign ram_wdata = {new_sum[2], new_sum[1], new_sum[0]};

   logic last_col, last_row, row_end;
   assign last_col = ({1'b0, cit_ff} == cs - KW'(1)) || ({1'b0, pc_ff} == w - DW'(1));
   assign last_row = ({1'b0, rit_ff} == cs - KW'(1)) || ({1'b0, pr_ff} == h - DW'(1));

   // clipped tile size
   logic [PW-1:0] tw_raw, th_raw;
   assign tw_raw = PW'(w) - col_base;
   assign th_raw = PW'(h) - row_base;

   // counter advance
   logic [DW-1:0] pc_inc, pr_inc;
   logic [KW-1:0] cit_inc, rit_inc;
   assign pc_inc  = DW'(pc_ff) + DW'(1);
   assign pr_inc  = DW'(pr_ff) + DW'(1);
   assign cit_inc = KW'(cit_ff) + KW'(1);
   assign rit_inc = KW'(rit_ff) + KW'(1);
   assign row_end = (pc_inc >= w);

   // divider step, one quotient bit per cycle per channel
   mtavg_pkg::sum_type dvd_in [3];
   logic [RW-1:0]      rem_in [3];
   always_comb begin
      logic [RW-1:0] trial;
      for (int c = 0; c < 3; c++) begin
         trial = {rem_ff[c][RW-2:0], dvd_ff[c][SW-1]};
         if (trial >= RW'(cnt_ff)) begin
            rem_in[c] = trial - RW'(cnt_ff);
            dvd_in[c] = {dvd_ff[c][SW-2:0], 1'b1};
         end else begin
            rem_in[c] = trial;
            dvd_in[c] = {dvd_ff[c][SW-2:0], 1'b0};
         end
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cell_ff      <= KW'(8);
         width_ff     <= DW'(640);
         height_ff    <= DW'(480);
         pc_ff        <= '0;
         pr_ff        <= '0;
         cit_ff       <= '0;
         rit_ff       <= '0;
         ctc_ff       <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mtavg_pkg::REG_TILE_SIDE:    cell_ff   <= csr_wdata[KW-1:0];
               mtavg_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               mtavg_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         // load a finished tile, or drop the result once it is taken
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  pix_ff[0] <= req_tdata[7:0];
                  pix_ff[1] <= req_tdata[15:8];
                  pix_ff[2] <= req_tdata[23:16];
                  state_ff  <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               // snap back to the frame origin if the counters went stale
               if (restart) begin
                  pc_ff  <= '0;
                  pr_ff  <= '0;
                  cit_ff <= '0;
                  rit_ff <= '0;
                  ctc_ff <= '0;
                  ctr_ff <= '0;
               end
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               tcol_ff  <= ctc_ff;
               trow_ff  <= ctr_ff;
               fdone_ff <= ({1'b0, pc_ff} == w - DW'(1)) && ({1'b0, pr_ff} == h - DW'(1));
               tw_ff    <= (tw_raw > PW'(cs)) ? cs : tw_raw[KW-1:0];
               th_ff    <= (th_raw > PW'(cs)) ? cs : th_raw[KW-1:0];
               for (int c = 0; c < 3; c++) begin
                  dvd_ff[c] <= new_sum[c];
                  rem_ff[c] <= '0;
               end
               // advance the raster position
               if (row_end) begin
                  pc_ff  <= '0;
                  cit_ff <= '0;
                  ctc_ff <= '0;
                  if (pr_inc >= h) begin
                     pr_ff  <= '0;
                     rit_ff <= '0;
                     ctr_ff <= '0;
                  end else begin
                     pr_ff <= pr_inc[CW-1:0];
                     if (rit_inc == cs) begin
                        rit_ff <= '0;
                        ctr_ff <= ctr_ff + CW'(1);
                     end else begin
                        rit_ff <= rit_inc[5:0];
                     end
                  end
               end else begin
                  pc_ff <= pc_inc[CW-1:0];
                  if (cit_inc == cs) begin
                     cit_ff <= '0;
                     ctc_ff <= ctc_ff + CW'(1);
                  end else begin
                     cit_ff <= cit_inc[5:0];
                  end
               end
               state_ff <= (last_col && last_row) ? ST_CNT : ST_IDLE;
            end
            ST_CNT: begin
               cnt_ff   <= DW'(tw_ff) * DW'(th_ff);
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  dvd_ff[c] <= dvd_in[c];
                  rem_ff[c] <= rem_in[c];
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(SW - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register frees up
               if (out_free) begin
                  rsp_data_ff  <= {dvd_ff[2][7:0], dvd_ff[1][7:0], dvd_ff[0][7:0],
                                   trow_ff, tcol_ff};
                  rsp_user_ff  <= fdone_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted request did not start a sum read");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < 5'(SW)))
      else $error("divider ran past its last step");

   a_ram_rmw: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> ram_we)
      else $error("sum read not followed by write back");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");
`endif

endmodule
